>>> src/mlpd_pkg.sv
// Package for the length-prefixed deframer: phase and status codes,
// the result record and the register map constants. No dependencies.
`default_nettype none

package mlpd_pkg;

  typedef enum logic [1:0] {
    PH_MAGIC   = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BADMAGIC = 2'd2
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic       last_of_message;
  } result_t;

  localparam int unsigned PaddrW      = 3;
  localparam logic        RegMagicIdx = 1'b0;
  localparam logic [7:0]  MagicReset  = 8'd77;
  localparam logic [1:0]  LenLastIdx  = 2'd3;

endpackage

`default_nettype wire

>>> src/mlpd_stream_if.sv
// Stream interfaces for the deframer: received bytes in, results out.
// Uses no package.
`default_nettype none

interface mlpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [1:0] status;
  logic       last_of_message;

  modport source (output valid, output payload_byte, output status,
                  output last_of_message, input ready);
  modport sink   (input valid, input payload_byte, input status,
                  input last_of_message, output ready);
endinterface

`default_nettype wire

>>> src/mlpd_parser.sv
// Header and payload tracking for the deframer: phase, length byte index
// and remaining count, plus the result for the byte being taken. Uses mlpd_pkg.
`default_nettype none

module mlpd_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic [7:0]      magic_i,
  output mlpd_pkg::result_t    res_o
);

  mlpd_pkg::phase_e phase_q, phase_d;
  logic [1:0]       len_idx_q, len_idx_d;
  logic [31:0]      remaining_q, remaining_d;

  logic [31:0] shifted;
  logic [31:0] decremented;

  assign shifted     = {remaining_q[23:0], rx_byte_i};
  assign decremented = remaining_q - 32'd1;

  // Next state.
  always_comb begin
    phase_d     = phase_q;
    len_idx_d   = len_idx_q;
    remaining_d = remaining_q;
    unique case (phase_q)
      mlpd_pkg::PH_LENGTH: begin
        remaining_d = shifted;
        if (len_idx_q == mlpd_pkg::LenLastIdx) begin
          len_idx_d = 2'd0;
          phase_d   = (shifted == 32'd0) ? mlpd_pkg::PH_MAGIC : mlpd_pkg::PH_PAYLOAD;
        end else begin
          len_idx_d = len_idx_q + 2'd1;
        end
      end
      mlpd_pkg::PH_PAYLOAD: begin
        remaining_d = decremented;
        if (decremented == 32'd0) begin
          phase_d = mlpd_pkg::PH_MAGIC;
        end
      end
      default: begin
        phase_d = mlpd_pkg::PH_MAGIC;
        if (rx_byte_i == magic_i) begin
          phase_d     = mlpd_pkg::PH_LENGTH;
          len_idx_d   = 2'd0;
          remaining_d = 32'd0;
        end
      end
    endcase
  end

  // Result for the byte being taken.
  always_comb begin
    res_o = '0;
    unique case (phase_q)
      mlpd_pkg::PH_LENGTH: begin
        if (len_idx_q == mlpd_pkg::LenLastIdx && shifted == 32'd0) begin
          res_o.valid           = 1'b1;
          res_o.status          = mlpd_pkg::ST_EMPTY;
          res_o.last_of_message = 1'b1;
        end
      end
      mlpd_pkg::PH_PAYLOAD: begin
        res_o.valid           = 1'b1;
        res_o.payload_byte    = rx_byte_i;
        res_o.status          = mlpd_pkg::ST_PAYLOAD;
        res_o.last_of_message = (decremented == 32'd0);
      end
      default: begin
        if (rx_byte_i != magic_i) begin
          res_o.valid  = 1'b1;
          res_o.status = mlpd_pkg::ST_BADMAGIC;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mlpd_pkg::PH_MAGIC;
      len_idx_q   <= 2'd0;
      remaining_q <= 32'd0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      len_idx_q   <= len_idx_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

`default_nettype wire

>>> src/magic_length_prefixed_deframer.sv
// Top level of the magic-byte length-prefixed deframer: stream channels,
// APB register port and result register. Uses mlpd_pkg, mlpd_parser and
// the stream interfaces in mlpd_stream_if.sv.
//
//  channel  direction  carries
//  rx_i     in         rx_byte, one received byte per item
//  tx_o     out        payload_byte, status, last_of_message
//  apb      in/out     magic_value register at byte address 0
//
// One byte is taken per cycle, and its result, if any, is offered from the
// result register in the next cycle. rx_i is held off only while a result
// waits in that register and tx_o is not ready; a byte that makes no result
// waits then as well. Reset clears the phase, length index, count and result
// valid, and loads magic_value with 77.
`default_nettype none

module magic_length_prefixed_deframer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  mlpd_in_if.sink                           rx_i,
  mlpd_out_if.source                        tx_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mlpd_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  logic [7:0]        magic_q;
  logic              accept;
  logic              cfg_wr;
  logic              out_valid_q, out_valid_d;
  mlpd_pkg::result_t res;
  logic [7:0]        payload_q;
  logic [1:0]        status_q;
  logic              last_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == mlpd_pkg::RegMagicIdx);
  assign prdata = (paddr[2] == mlpd_pkg::RegMagicIdx) ? {24'd0, magic_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= mlpd_pkg::MagicReset;
    end else if (cfg_wr) begin
      magic_q <= pwdata[7:0];
    end
  end

  assign rx_i.ready = !out_valid_q || tx_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  mlpd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .magic_i   (magic_q),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res.valid;
    end else if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      payload_q <= res.payload_byte;
      status_q  <= res.status;
      last_q    <= res.last_of_message;
    end
  end

  assign tx_o.valid           = out_valid_q;
  assign tx_o.payload_byte    = payload_q;
  assign tx_o.status          = status_q;
  assign tx_o.last_of_message = last_q;

  // A byte is never taken while an untaken result would be overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!out_valid_q || tx_o.ready))
    else $error("item accepted over a pending result");

  // Discard results carry neither data nor an end mark.
  a_badmagic_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_o.valid && tx_o.status == mlpd_pkg::ST_BADMAGIC)
      |-> (!tx_o.last_of_message && tx_o.payload_byte == 8'd0))
    else $error("discard result with data or end mark");

  // An empty-message result always ends its message with zero data.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_o.valid && tx_o.status == mlpd_pkg::ST_EMPTY)
      |-> (tx_o.last_of_message && tx_o.payload_byte == 8'd0))
    else $error("empty-message result malformed");

  // A result appears only after an accepted item.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept))
    else $error("result without an accepted item");

endmodule

`default_nettype wire
